[rtl/rank_to_normal_quantile_assert.svh]
// Assertion macros used by the checker file of the rank-to-quantile block.
// Users provide clk and rst in the enclosing scope.
`ifndef RANK_TO_NORMAL_QUANTILE_ASSERT_SVH
`define RANK_TO_NORMAL_QUANTILE_ASSERT_SVH

// same-cycle implication
`define RTNQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTNQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rtnq_pkg.sv]
// Shared constants and types for the rank-to-normal-quantile pipeline.
// No dependencies.
`default_nettype none
package rtnq_pkg;

  localparam int RANK_BITS     = 16;
  localparam int IN_TDATA_W    = ((RANK_BITS + 7) / 8) * 8;
  localparam int CNT_W         = 16;
  localparam int CMP_W         = (RANK_BITS > CNT_W) ? RANK_BITS : CNT_W;
  localparam int D_W           = CNT_W + 1;
  localparam int OUT_W         = 16;
  localparam int OUT_FRAC_BITS = 12;

  // internal fixed point: 28 fractional bits
  localparam int FB    = 28;
  localparam int E_W   = 5;
  localparam int LOG_W = E_W + FB;
  localparam int M_W   = FB + 1;

  localparam int SQ_STAGES = 32;
  localparam int NUM_W     = 32;
  localparam int Q_W       = 31;
  localparam int R_W       = NUM_W + 1;
  localparam int LO_W      = Q_W - FB;

  localparam int LOG_LAT = FB + 1;
  localparam int SIDE_N  = 1 + LOG_LAT + 2 + SQ_STAGES + 4 + Q_W;
  localparam int T_N     = 4 + Q_W;
  localparam int Z_W     = 34;
  localparam int SH      = FB - OUT_FRAC_BITS;

  localparam logic [31:0] C0 = 32'(((64'd2515517 << FB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] C1 = 32'(((64'd802853 << FB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] C2 = 32'(((64'd10328 << FB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] D1 = 32'(((64'd1432788 << FB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] D2 = 32'(((64'd189269 << FB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] D3 = 32'(((64'd1308 << FB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] ONE_Q = 32'(64'd1 << FB);
  localparam logic [31:0] LN2_Q = 32'd186065279;

  localparam logic signed [Z_W-1:0] LIM = Z_W'(64'd5 << OUT_FRAC_BITS);
  localparam logic [OUT_W-1:0] OUT_LIM = OUT_W'(64'd5 << OUT_FRAC_BITS);

  typedef struct packed {
    logic vld;
    logic lower;
    logic clamp;
  } side_t;

endpackage
`default_nettype wire

[rtl/rank_to_normal_quantile.sv]
// One rank is accepted per cycle while the output is not stalled.
// The depth comes from the 28 log2 squaring stages, 32 square-root stages and the
// 31 divider stages; all stages advance together and hold while the output stalls.
// Reset (rst, synchronous): clears all valid bits, sample_count returns to 1.
// Uses rtnq_pkg, rtnq_log2, rtnq_sqrt, rtnq_div.
`default_nettype none
module rank_to_normal_quantile (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [rtnq_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rtnq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [RANK_BITS-1:0] rank
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rtnq_pkg::OUT_W-1:0]        m_axis_tdata,  // [15:0] quantile
  output logic                              m_axis_tuser   // [0] clamped
);

  logic                       en;
  logic [rtnq_pkg::CNT_W-1:0] sample_count;

  logic [rtnq_pkg::CMP_W-1:0]   rank_x, cnt_x;
  logic [rtnq_pkg::CMP_W+1:0]   two_r, cnt_p1;
  logic                         clamp_in, lower_in;
  logic [rtnq_pkg::D_W-1:0]     a_in, d_in;
  logic [rtnq_pkg::D_W-1:0]     a_r, d_r;

  rtnq_pkg::side_t sd [0:rtnq_pkg::SIDE_N-1];

  logic [rtnq_pkg::LOG_W-1:0] lg_a, lg_d;
  logic [rtnq_pkg::LOG_W-1:0] lg_r;
  logic [63:0]                prod_r;
  logic [63:0]                sq_in;
  logic [31:0]                t;

  logic [63:0] pn1, pd1, pn2, pd2, pd3;
  logic [31:0] num_r, num_h4, den_h4;
  logic [31:0] tdl [0:rtnq_pkg::T_N-1];
  logic [rtnq_pkg::Q_W-1:0] ratio;

  logic signed [rtnq_pkg::Z_W-1:0] z, zmag, mag, rv, rs;
  logic                            neg;

  logic                       o_vld;
  logic [rtnq_pkg::OUT_W-1:0] o_q;
  logic                       o_c;

  assign en            = !o_vld || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= rtnq_pkg::CNT_W'(1);
    end else if (cfg_wr_en) begin
      sample_count <= cfg_wr_data;
    end
  end

  // entry: classify rank, pick tail count a and divisor d = count + 1
  always_comb begin
    rank_x   = rtnq_pkg::CMP_W'(s_axis_tdata[rtnq_pkg::RANK_BITS-1:0]);
    cnt_x    = rtnq_pkg::CMP_W'(sample_count);
    clamp_in = rank_x >= cnt_x;
    two_r    = {1'b0, rank_x, 1'b0} + (rtnq_pkg::CMP_W+2)'(2);
    cnt_p1   = (rtnq_pkg::CMP_W+2)'(cnt_x) + (rtnq_pkg::CMP_W+2)'(1);
    lower_in = two_r < cnt_p1;
    a_in     = lower_in ? rtnq_pkg::D_W'(rank_x + rtnq_pkg::CMP_W'(1))
                        : rtnq_pkg::D_W'(cnt_x - rank_x);
    d_in     = rtnq_pkg::D_W'(sample_count) + rtnq_pkg::D_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_in;
      d_r <= d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < rtnq_pkg::SIDE_N; k++) sd[k] <= '0;
    end else if (en) begin
      sd[0] <= '{vld: s_axis_tvalid, lower: lower_in, clamp: clamp_in};
      for (int k = 1; k < rtnq_pkg::SIDE_N; k++) sd[k] <= sd[k-1];
    end
  end

  rtnq_log2 u_log_a (.clk(clk), .en(en), .x(a_r), .lg(lg_a));
  rtnq_log2 u_log_d (.clk(clk), .en(en), .x(d_r), .lg(lg_d));

  // s = -2 ln q = 2 ln2 * (log2 d - log2 a)
  always_ff @(posedge clk) begin
    if (en) begin
      lg_r   <= (lg_d > lg_a) ? (lg_d - lg_a) : '0;
      prod_r <= 64'(lg_r) * 64'(rtnq_pkg::LN2_Q);
    end
  end

  assign sq_in = (prod_r >> (rtnq_pkg::FB - 1)) << rtnq_pkg::FB;

  rtnq_sqrt u_sqrt (.clk(clk), .en(en), .v(sq_in), .t(t));

  // Horner evaluation of numerator and denominator
  always_ff @(posedge clk) begin
    if (en) begin
      pn1    <= 64'(rtnq_pkg::C2) * 64'(t);
      pd1    <= 64'(rtnq_pkg::D3) * 64'(t);
      pn2    <= 64'(32'(pn1 >> rtnq_pkg::FB) + rtnq_pkg::C1) * 64'(tdl[0]);
      pd2    <= 64'(32'(pd1 >> rtnq_pkg::FB) + rtnq_pkg::D2) * 64'(tdl[0]);
      num_r  <= 32'(pn2 >> rtnq_pkg::FB) + rtnq_pkg::C0;
      pd3    <= 64'(32'(pd2 >> rtnq_pkg::FB) + rtnq_pkg::D1) * 64'(tdl[1]);
      num_h4 <= num_r;
      den_h4 <= 32'(pd3 >> rtnq_pkg::FB) + rtnq_pkg::ONE_Q;
      tdl[0] <= t;
      for (int k = 1; k < rtnq_pkg::T_N; k++) tdl[k] <= tdl[k-1];
    end
  end

  rtnq_div u_div (.clk(clk), .en(en), .num(num_h4), .den(den_h4), .q(ratio));

  // z = t - ratio, round half away from zero, apply sign, limit
  always_comb begin
    z    = $signed({2'b00, tdl[rtnq_pkg::T_N-1]}) - $signed({3'b000, ratio});
    zmag = z[rtnq_pkg::Z_W-1] ? -z : z;
    mag  = (zmag + (rtnq_pkg::Z_W'(1) <<< (rtnq_pkg::SH - 1))) >>> rtnq_pkg::SH;
    neg  = z[rtnq_pkg::Z_W-1] ^ sd[rtnq_pkg::SIDE_N-1].lower;
    rv   = neg ? -mag : mag;
    if (rv > rtnq_pkg::LIM) begin
      rs = rtnq_pkg::LIM;
    end else if (rv < -rtnq_pkg::LIM) begin
      rs = -rtnq_pkg::LIM;
    end else begin
      rs = rv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= sd[rtnq_pkg::SIDE_N-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_c <= sd[rtnq_pkg::SIDE_N-1].clamp;
      o_q <= sd[rtnq_pkg::SIDE_N-1].clamp ? rtnq_pkg::OUT_LIM : rs[rtnq_pkg::OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = o_vld;
  assign m_axis_tdata  = o_q;
  assign m_axis_tuser  = o_c;

endmodule
`default_nettype wire

[rtl/rtnq_log2.sv]
// Pipelined log2 in fixed point: one normalize stage, then one squaring per stage.
// Uses rtnq_pkg.
`default_nettype none
module rtnq_log2 (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rtnq_pkg::D_W-1:0]     x,
  output logic [rtnq_pkg::LOG_W-1:0]   lg
);

  logic [rtnq_pkg::E_W-1:0] e0;
  logic [rtnq_pkg::M_W-1:0] m0;
  logic [rtnq_pkg::E_W-1:0] e_r;
  logic [rtnq_pkg::M_W-1:0] m_r;

  wire [rtnq_pkg::M_W-1:0] m_w [0:rtnq_pkg::FB];
  wire [rtnq_pkg::FB-1:0]  f_w [0:rtnq_pkg::FB];
  wire [rtnq_pkg::E_W-1:0] e_w [0:rtnq_pkg::FB];

  // leading one position and mantissa in [1,2)
  always_comb begin
    e0 = '0;
    for (int i = 0; i < rtnq_pkg::D_W; i++) begin
      if (x[i]) e0 = rtnq_pkg::E_W'(i);
    end
    m0 = rtnq_pkg::M_W'(x) << (rtnq_pkg::E_W'(rtnq_pkg::FB) - e0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e0;
      m_r <= m0;
    end
  end

  assign m_w[0] = m_r;
  assign f_w[0] = '0;
  assign e_w[0] = e_r;

  for (genvar i = 1; i <= rtnq_pkg::FB; i++) begin : g_sq
    logic [2*rtnq_pkg::M_W-1:0] sq;
    logic [rtnq_pkg::M_W:0]     mm;
    logic [rtnq_pkg::M_W-1:0]   m_q;
    logic [rtnq_pkg::FB-1:0]    f_q;
    logic [rtnq_pkg::E_W-1:0]   e_q;

    assign sq = m_w[i-1] * m_w[i-1];
    assign mm = sq[rtnq_pkg::FB+rtnq_pkg::M_W:rtnq_pkg::FB];

    always_ff @(posedge clk) begin
      if (en) begin
        if (mm[rtnq_pkg::M_W]) begin
          m_q <= mm[rtnq_pkg::M_W:1];
          f_q <= f_w[i-1] | (rtnq_pkg::FB'(1) << (rtnq_pkg::FB - i));
        end else begin
          m_q <= mm[rtnq_pkg::M_W-1:0];
          f_q <= f_w[i-1];
        end
        e_q <= e_w[i-1];
      end
    end

    assign m_w[i] = m_q;
    assign f_w[i] = f_q;
    assign e_w[i] = e_q;
  end

  assign lg = {e_w[rtnq_pkg::FB], f_w[rtnq_pkg::FB]};

endmodule
`default_nettype wire

[rtl/rtnq_sqrt.sv]
// Pipelined bit-serial integer square root, one result bit per stage.
// Uses rtnq_pkg.
`default_nettype none
module rtnq_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v,
  output logic [31:0] t
);

  wire [63:0] rem_w [0:rtnq_pkg::SQ_STAGES];
  wire [63:0] res_w [0:rtnq_pkg::SQ_STAGES];

  assign rem_w[0] = v;
  assign res_w[0] = '0;

  for (genvar i = 0; i < rtnq_pkg::SQ_STAGES; i++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (2 * (rtnq_pkg::SQ_STAGES - 1 - i));
    logic [63:0] trial;
    logic [63:0] rem_q;
    logic [63:0] res_q;

    assign trial = res_w[i] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_w[i] >= trial) begin
          rem_q <= rem_w[i] - trial;
          res_q <= (res_w[i] >> 1) + BIT;
        end else begin
          rem_q <= rem_w[i];
          res_q <= res_w[i] >> 1;
        end
      end
    end

    assign rem_w[i+1] = rem_q;
    assign res_w[i+1] = res_q;
  end

  assign t = res_w[rtnq_pkg::SQ_STAGES][31:0];

endmodule
`default_nettype wire

[rtl/rtnq_div.sv]
// Pipelined restoring divider: q = floor(num * 2^FB / den), one quotient bit per stage.
// Uses rtnq_pkg; the quotient is known to fit Q_W bits.
`default_nettype none
module rtnq_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rtnq_pkg::NUM_W-1:0]   num,
  input  logic [31:0]                  den,
  output logic [rtnq_pkg::Q_W-1:0]     q
);

  wire [rtnq_pkg::R_W-1:0]  rem_w [0:rtnq_pkg::Q_W];
  wire [31:0]               den_w [0:rtnq_pkg::Q_W];
  wire [rtnq_pkg::LO_W-1:0] lo_w  [0:rtnq_pkg::Q_W];
  wire [rtnq_pkg::Q_W-1:0]  q_w   [0:rtnq_pkg::Q_W];

  assign rem_w[0] = rtnq_pkg::R_W'(num >> rtnq_pkg::LO_W);
  assign den_w[0] = den;
  assign lo_w[0]  = num[rtnq_pkg::LO_W-1:0];
  assign q_w[0]   = '0;

  for (genvar j = 0; j < rtnq_pkg::Q_W; j++) begin : g_st
    localparam int B = rtnq_pkg::Q_W - 1 - j;
    logic                     inbit;
    logic [rtnq_pkg::R_W-1:0] sh;
    logic [rtnq_pkg::R_W-1:0] rem_q;
    logic [31:0]              den_q;
    logic [rtnq_pkg::LO_W-1:0] lo_q;
    logic [rtnq_pkg::Q_W-1:0] q_q;

    if (B >= rtnq_pkg::FB) begin : g_bit
      assign inbit = lo_w[j][B-rtnq_pkg::FB];
    end else begin : g_zero
      assign inbit = 1'b0;
    end

    assign sh = {rem_w[j][rtnq_pkg::R_W-2:0], inbit};

    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= {1'b0, den_w[j]}) begin
          rem_q <= sh - {1'b0, den_w[j]};
          q_q   <= {q_w[j][rtnq_pkg::Q_W-2:0], 1'b1};
        end else begin
          rem_q <= sh;
          q_q   <= {q_w[j][rtnq_pkg::Q_W-2:0], 1'b0};
        end
        den_q <= den_w[j];
        lo_q  <= lo_w[j];
      end
    end

    assign rem_w[j+1] = rem_q;
    assign den_w[j+1] = den_q;
    assign lo_w[j+1]  = lo_q;
    assign q_w[j+1]   = q_q;
  end

  assign q = q_w[rtnq_pkg::Q_W];

endmodule
`default_nettype wire

[rtl/rtnq_check.sv]
// Port-level checker for rank_to_normal_quantile, bound to the top level.
// Uses rtnq_pkg and rank_to_normal_quantile_assert.svh.
`default_nettype none
`include "rank_to_normal_quantile_assert.svh"
module rtnq_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [rtnq_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                       m_axis_tuser
);

  `RTNQ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")
  `RTNQ_ASSERT_NOW(a_clamp_val, m_axis_tvalid && m_axis_tuser, m_axis_tdata == rtnq_pkg::OUT_LIM, "clamped result is not +5")
  `RTNQ_ASSERT_NOW(a_range, m_axis_tvalid, ($signed(m_axis_tdata) <= $signed(rtnq_pkg::OUT_LIM)) && ($signed(m_axis_tdata) >= -$signed(rtnq_pkg::OUT_LIM)), "quantile out of range")
  `RTNQ_ASSERT_NOW(a_no_block, m_axis_tready || !m_axis_tvalid, s_axis_tready, "input stalled without output backpressure")

endmodule

bind rank_to_normal_quantile rtnq_check u_rtnq_check (.*);
`default_nettype wire
